// ----- hw/rtl/htcd_pkg.sv -----
// Shared types and constants of the hashed tile cache directory.
// No dependencies; every other file of the block but htcd_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package htcd_pkg;

    localparam int COORD_W    = 16;
    localparam int LEVEL_W    = 5;
    localparam int FRAME_W    = 31;
    localparam int STAMP_W    = 32;
    localparam int BUILD_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 5'd16;
    localparam logic [31:0]        Z_MULT      = 32'd97;
    localparam logic [31:0]        LEVEL_MULT  = 32'd193;
    localparam logic [BUILD_W-1:0] BUILD_MAX   = 8'd255;
    localparam logic [BUILD_W-1:0] BUILD_RESET = 8'd3;

    localparam logic               CMD_LOOKUP = 1'b0;
    localparam logic               CMD_FLUSH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BUILD_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DECIDE,
        ST_HIT,
        ST_ALLOC,
        ST_FLUSH_DONE
    } t_state;

    // one directory slot as stored in the memory
    typedef struct packed {
        logic                 valid;
        logic [STAMP_W-1:0]   last_used;
        logic [LEVEL_W-1:0]   level;
        logic [COORD_W-1:0]   z;
        logic [COORD_W-1:0]   x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [COORD_W-1:0] clear_below(
        input logic [COORD_W-1:0] v,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [31:0] m;
        m = ~((32'd1 << lvl) - 32'd1);
        return v & m[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/htcd_req_if.sv -----
// Request channel of the hashed tile cache directory.
// Depends on htcd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface htcd_req_if;
    import htcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] x_index;
    logic [COORD_W-1:0] z_index;
    logic [LEVEL_W-1:0] req_level;
    logic [FRAME_W-1:0] frame_number;

    modport source (output valid, command, x_index, z_index, req_level, frame_number,
                    input ready);
    modport sink   (input valid, command, x_index, z_index, req_level, frame_number,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/htcd_rsp_if.sv -----
// Result channel of the hashed tile cache directory.
// Depends on htcd_pkg for field widths; slot width follows the hash width.
`timescale 1ns / 1ps
`default_nettype none

interface htcd_rsp_if #(parameter int SLOT_W = 13);
    import htcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] granted_level;
    logic [COORD_W-1:0] granted_x;
    logic [COORD_W-1:0] granted_z;
    logic               built_new;
    logic               victim_valid;
    logic               thrash;

    modport source (output valid, hit, slot, granted_level, granted_x, granted_z,
                    built_new, victim_valid, thrash, input ready);
    modport sink   (input valid, hit, slot, granted_level, granted_x, granted_z,
                    built_new, victim_valid, thrash, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hashed_tile_cache_directory.sv -----
// Channel  | Dir | Carries
// i_req    | in  | command, x_index, z_index, req_level, frame_number
// o_rsp    | out | hit, slot, granted_level/x/z, built_new, victim_valid, thrash
// i_cfg_*  | in  | build_limit (index 0), min_level (index 1)
//
// A lookup is accepted in the idle state; then each probe window runs a hash
// step, reads PROBE_WINDOW slots through the slot memory read port and runs a
// decide step, for up to MAX_ESCALATIONS+1 windows, followed by a commit step.
// A hit leaves the window at the matching slot and skips the decide step. The
// commit step is held while the output register still holds an untaken result.
// A flush and the reset each run a clearing pass over all 2**HASH_WIDTH slots
// (8192 by default) through the memory write port; no request is taken then.
// A finished result sits in the output register while the next request enters.
// Depends on htcd_pkg, htcd_req_if, htcd_rsp_if and htcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module hashed_tile_cache_directory #(
    parameter int HASH_WIDTH      = 13,
    parameter int PROBE_WINDOW    = 15,
    parameter int MAX_ESCALATIONS = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [htcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [htcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    htcd_req_if.sink                             i_req,
    htcd_rsp_if.source                           o_rsp
);
    import htcd_pkg::*;

    localparam int CNT_W   = $clog2(PROBE_WINDOW + 1);
    localparam int RAISE_W = $clog2(MAX_ESCALATIONS + 2);

    t_state r_state, n_state;

    logic [BUILD_W-1:0]    r_build_limit;
    logic [LEVEL_W-1:0]    r_min_level;
    logic [BUILD_W-1:0]    r_built;
    logic [FRAME_W-1:0]    r_prev;
    logic [HASH_WIDTH-1:0] r_clr_addr;
    logic                  r_flush;

    logic [COORD_W-1:0]    r_x, r_z;
    logic [LEVEL_W-1:0]    r_level;
    logic [FRAME_W-1:0]    r_frame;
    logic [RAISE_W-1:0]    r_raises;
    logic [HASH_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_issue, r_seen;
    logic                  r_rd_vld;
    logic [HASH_WIDTH-1:0] r_rd_idx;
    logic [STAMP_W-1:0]    r_oldest;
    logic [HASH_WIDTH-1:0] r_victim;
    logic                  r_vict_valid;
    logic                  r_found;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [HASH_WIDTH-1:0] r_out_slot;
    logic [LEVEL_W-1:0]    r_out_level;
    logic [COORD_W-1:0]    r_out_x, r_out_z;
    logic                  r_out_built, r_out_vv, r_out_thrash;

    logic                  accept, out_free, issue, match, older, last_seen, escalate;
    logic                  mem_we;
    logic [HASH_WIDTH-1:0] mem_waddr, mem_raddr;
    t_entry                mem_wdata, rd_q;
    logic [ENTRY_W-1:0]    mem_rdata;
    logic [31:0]           hash_sum;

    htcd_ram #(.WIDTH(ENTRY_W), .ADDR_W(HASH_WIDTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_q      = t_entry'(mem_rdata);
    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign issue     = (r_issue != CNT_W'(PROBE_WINDOW));
    assign match     = rd_q.valid && rd_q.x == r_x && rd_q.z == r_z && rd_q.level == r_level;
    assign older     = $signed(rd_q.last_used) < $signed(r_oldest);
    assign last_seen = (r_seen == CNT_W'(PROBE_WINDOW - 1));
    assign escalate  = (r_raises < RAISE_W'(MAX_ESCALATIONS)) && (r_built >= r_build_limit)
                       && (r_level < TOP_LEVEL);
    assign hash_sum  = 32'(r_x >> r_level) + 32'(r_z >> r_level) * Z_MULT
                       + 32'(r_level) * LEVEL_MULT;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) n_state = r_flush ? ST_FLUSH_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = (i_req.command == CMD_FLUSH) ? ST_CLEAR : ST_HASH;
            end
            ST_HASH:   n_state = ST_PROBE;
            ST_PROBE: begin
                if (r_rd_vld && match)          n_state = ST_HIT;
                else if (r_rd_vld && last_seen) n_state = ST_DECIDE;
            end
            ST_DECIDE: n_state = escalate ? ST_HASH : ST_ALLOC;
            ST_HIT, ST_ALLOC, ST_FLUSH_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_victim;
        mem_wdata = '{valid: 1'b1, last_used: {1'b0, r_frame}, level: r_level,
                      z: r_z, x: r_x};
        mem_raddr = r_key + HASH_WIDTH'(r_issue);
        i_req.ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '{valid: 1'b0, last_used: '1, level: '0, z: '0, x: '0};
            end
            ST_HIT, ST_ALLOC: mem_we = out_free;
            default: ;
        endcase
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.granted_level = r_out_level;
    assign o_rsp.granted_x     = r_out_x;
    assign o_rsp.granted_z     = r_out_z;
    assign o_rsp.built_new     = r_out_built;
    assign o_rsp.victim_valid  = r_out_vv;
    assign o_rsp.thrash        = r_out_thrash;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_flush       <= 1'b0;
            r_build_limit <= BUILD_RESET;
            r_min_level   <= '0;
            r_built       <= '0;
            r_prev        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BUILD_LIMIT: r_build_limit <= i_cfg_data;
                    REG_MIN_LEVEL:   r_min_level   <= i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (accept) begin
                r_flush <= (i_req.command == CMD_FLUSH);
                if (i_req.command == CMD_LOOKUP && i_req.frame_number != r_prev) begin
                    r_built <= '0;
                    r_prev  <= i_req.frame_number;
                end
            end
            if (r_state == ST_ALLOC && out_free && r_built != BUILD_MAX) begin
                r_built <= r_built + 1'b1;
            end
            if ((r_state == ST_HIT || r_state == ST_ALLOC || r_state == ST_FLUSH_DONE)
                && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_frame  <= i_req.frame_number;
                r_raises <= '0;
                if (i_req.req_level < r_min_level) begin
                    r_level <= r_min_level;
                    r_x     <= clear_below(i_req.x_index, r_min_level);
                    r_z     <= clear_below(i_req.z_index, r_min_level);
                end else begin
                    r_level <= i_req.req_level;
                    r_x     <= i_req.x_index;
                    r_z     <= i_req.z_index;
                end
            end
            ST_HASH: begin
                r_key    <= hash_sum[HASH_WIDTH-1:0];
                r_issue  <= '0;
                r_seen   <= '0;
                r_rd_vld <= 1'b0;
                r_oldest <= {1'b0, r_frame};
                r_found  <= 1'b0;
            end
            ST_PROBE: begin
                r_rd_vld <= issue;
                r_rd_idx <= mem_raddr;
                if (issue) r_issue <= r_issue + 1'b1;
                if (r_rd_vld) begin
                    r_seen <= r_seen + 1'b1;
                    if (match) begin
                        r_victim <= r_rd_idx;
                    end else if (older) begin
                        r_oldest     <= rd_q.last_used;
                        r_victim     <= r_rd_idx;
                        r_vict_valid <= rd_q.valid;
                        r_found      <= 1'b1;
                    end else if (r_seen == '0) begin
                        // first slot of the window is the fallback victim
                        r_victim     <= r_rd_idx;
                        r_vict_valid <= rd_q.valid;
                    end
                end
            end
            ST_DECIDE: begin
                if (escalate) begin
                    r_level  <= r_level + 1'b1;
                    r_x      <= clear_below(r_x, r_level + 1'b1);
                    r_z      <= clear_below(r_z, r_level + 1'b1);
                    r_raises <= r_raises + 1'b1;
                end
            end
            ST_HIT, ST_ALLOC: begin
                if (out_free) begin
                    r_out_hit    <= (r_state == ST_HIT);
                    r_out_slot   <= r_victim;
                    r_out_level  <= r_level;
                    r_out_x      <= r_x;
                    r_out_z      <= r_z;
                    r_out_built  <= (r_state == ST_ALLOC);
                    r_out_vv     <= (r_state == ST_ALLOC) && r_vict_valid;
                    r_out_thrash <= (r_state == ST_ALLOC) && !r_found;
                end
            end
            ST_FLUSH_DONE: begin
                if (out_free) begin
                    r_out_hit    <= 1'b0;
                    r_out_slot   <= '0;
                    r_out_level  <= '0;
                    r_out_x      <= '0;
                    r_out_z      <= '0;
                    r_out_built  <= 1'b0;
                    r_out_vv     <= 1'b0;
                    r_out_thrash <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    a_no_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE || r_state == ST_DECIDE) |-> !mem_we)
        else $error("slot memory written during probe");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken back to back");

    a_raise_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HASH) |-> (r_raises <= RAISE_W'(MAX_ESCALATIONS)))
        else $error("too many level raises");

    a_alloc_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |-> $past(r_state) == ST_DECIDE || $past(r_state) == ST_ALLOC)
        else $error("allocation without finished probe");
endmodule

`default_nettype wire

// ----- hw/rtl/htcd_ram.sv -----
// Simple dual-port memory holding the directory slots.
// One write and one registered read per cycle; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htcd_ram #(
    parameter int WIDTH  = 70,
    parameter int ADDR_W = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for the hashed tile cache directory.
// Depends on htcd_pkg, htcd_req_if, htcd_rsp_if and the directory top level.
`timescale 1ns / 1ps

module tb_top;
    import htcd_pkg::*;

    localparam int  SLOTS      = 8192;
    localparam int  WINDOW     = 15;
    localparam int  MAX_RAISES = 3;
    localparam int  LIMIT      = 4000000;
    localparam int  SETTLE     = 120;
    localparam int  FLUSH_WAIT = 8400;

    typedef struct packed {
        logic               hit;
        logic [12:0]        slot;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        logic               built_new;
        logic               victim_valid;
        logic               thrash;
    } t_tile_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_BUILD_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    htcd_req_if        req_ch ();
    htcd_rsp_if #(13)  rsp_ch ();

    hashed_tile_cache_directory i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // directory mirror
    logic [15:0] dir_x [SLOTS];
    logic [15:0] dir_z [SLOTS];
    logic [4:0]  dir_lvl [SLOTS];
    bit          dir_valid [SLOTS];
    int          dir_stamp [SLOTS];
    int unsigned build_count;
    logic [30:0] last_frame;
    int unsigned build_budget;
    logic [4:0]  level_floor;

    t_tile_result tile_q [$];
    int   errors;
    int   cycles;
    int   hold_left;
    bit   last_flush;

    // sender state
    logic [30:0] cur_frame;
    logic [15:0] pool_x [24];
    logic [15:0] pool_z [24];

    function automatic logic [31:0] clear_low(logic [31:0] v, logic [4:0] lvl);
        return v & ~((32'd1 << lvl) - 32'd1);
    endfunction

    function automatic logic [31:0] tile_key(logic [31:0] x, logic [31:0] z, logic [4:0] lvl);
        logic [31:0] s;
        s = (x >> lvl) + (z >> lvl) * 32'd97 + {27'd0, lvl} * 32'd193;
        return s & (SLOTS - 1);
    endfunction

    function automatic void model_request(logic cmd, logic [15:0] x_in, logic [15:0] z_in,
                                          logic [4:0] lvl_in, logic [30:0] frame);
        logic [31:0]  x, z, key, idx, victim;
        logic [4:0]   lvl;
        int           raises;
        bit           found, settled;
        longint       oldest;
        t_tile_result r;
        r = '0;
        if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < SLOTS; i++) begin
                dir_valid[i] = 0;
                dir_stamp[i] = -1;
            end
            tile_q.push_back(r);
            return;
        end
        if (frame != last_frame) begin
            build_count = 0;
            last_frame = frame;
        end
        x = {16'd0, x_in};
        z = {16'd0, z_in};
        lvl = lvl_in;
        if (lvl < level_floor) begin
            lvl = level_floor;
            x = clear_low(x, lvl);
            z = clear_low(z, lvl);
        end
        raises = 0;
        settled = 0;
        victim = 0;
        found = 0;
        while (!settled) begin
            key = tile_key(x, z, lvl);
            found = 0;
            victim = key;
            oldest = longint'(frame);
            for (int i = 0; i < WINDOW; i++) begin
                idx = (key + i) & (SLOTS - 1);
                if (dir_valid[idx] && dir_x[idx] == x[15:0] && dir_z[idx] == z[15:0] &&
                    dir_lvl[idx] == lvl) begin
                    dir_stamp[idx] = int'({1'b0, frame});
                    r.hit = 1'b1;
                    r.slot = idx[12:0];
                    r.level = lvl;
                    r.x = x[15:0];
                    r.z = z[15:0];
                    tile_q.push_back(r);
                    return;
                end
                if (longint'(dir_stamp[idx]) < oldest) begin
                    oldest = dir_stamp[idx];
                    victim = idx;
                    found = 1;
                end
            end
            if (raises < MAX_RAISES && build_count >= build_budget && lvl < TOP_LEVEL) begin
                lvl = lvl + 5'd1;
                x = clear_low(x, lvl);
                z = clear_low(z, lvl);
                raises++;
            end else begin
                settled = 1;
            end
        end
        r.built_new = 1'b1;
        r.victim_valid = dir_valid[victim];
        r.thrash = !found;
        dir_x[victim] = x[15:0];
        dir_z[victim] = z[15:0];
        dir_lvl[victim] = lvl;
        dir_valid[victim] = 1;
        dir_stamp[victim] = int'({1'b0, frame});
        if (build_count < 255) build_count++;
        r.slot = victim[12:0];
        r.level = lvl;
        r.x = x[15:0];
        r.z = z[15:0];
        tile_q.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 90);
    endfunction

    // drive one request and hold it until accepted
    task automatic send_request(logic cmd, logic [15:0] x, logic [15:0] z,
                                logic [4:0] lvl, logic [30:0] frame);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.command = cmd;
        req_ch.x_index = x;
        req_ch.z_index = z;
        req_ch.req_level = lvl;
        req_ch.frame_number = frame;
        do @(posedge i_clk); while (!req_ch.ready);
        model_request(cmd, x, z, lvl, frame);
        last_flush = (cmd == CMD_FLUSH);
        @(negedge i_clk);
    endtask

    task automatic lookup(logic [15:0] x, logic [15:0] z, logic [4:0] lvl, logic [30:0] frame);
        send_request(CMD_LOOKUP, x, z, lvl, frame);
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        while (tile_q.size() != 0) @(negedge i_clk);
        repeat (last_flush ? FLUSH_WAIT : SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_BUILD_LIMIT) build_budget = val;
        else level_floor = val[4:0];
    endtask

    task automatic test_extremes();
        lookup(16'h0000, 16'h0000, 5'd0, 31'd0);
        lookup(16'h0000, 16'h0000, 5'd0, 31'd0);
        lookup(16'hFFFF, 16'hFFFF, 5'd0, 31'd0);
        lookup(16'hFFFF, 16'hFFFF, 5'd16, 31'h7FFFFFFF);
        lookup(16'hFFFF, 16'h0000, 5'd31, 31'h7FFFFFFF);
        lookup(16'h1234, 16'hABCD, 5'd17, 31'h40000000);
        lookup(16'hFFFF, 16'hFFFF, 5'd0, 31'h7FFFFFFF);
        lookup(16'hFFFF, 16'hFFFF, 5'd0, 31'h7FFFFFFF);
    endtask

    // exhaust the build budget so lookups fall back to coarser levels
    task automatic test_budget_fallback();
        for (int i = 0; i < 6; i++) lookup(16'(i * 3 + 1), 16'(i + 7), 5'd2, 31'd5);
        lookup(16'd15, 16'd10, 5'd15, 31'd5);
        lookup(16'd1, 16'd7, 5'd2, 31'd6);
    endtask

    // every slot in one window claimed this frame
    task automatic test_thrash();
        write_reg(REG_BUILD_LIMIT, 8'd255);
        for (int j = 0; j <= 16; j++) lookup(16'(97 * (16 - j)), 16'(j), 5'd0, 31'd9);
    endtask

    task automatic test_flush();
        send_request(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 5'd31, 31'h7FFFFFFF);
        lookup(16'h0000, 16'h0000, 5'd0, 31'd9);
        lookup(16'h0000, 16'h0000, 5'd0, 31'd9);
    endtask

    task automatic random_request();
        int r, p;
        logic [15:0] x, z;
        logic [4:0]  lvl;
        r = $urandom_range(0, 999);
        if (r < 8) begin
            send_request(CMD_FLUSH, 16'($urandom), 16'($urandom), 5'($urandom), cur_frame);
            return;
        end
        if ($urandom_range(0, 9) == 0) cur_frame = cur_frame + 31'd1;
        if ($urandom_range(0, 99) == 0) cur_frame = 31'($urandom);
        p = $urandom_range(0, 23);
        if (r < 750) begin
            x = pool_x[p];
            z = pool_z[p];
            lvl = 5'($urandom_range(0, 4));
        end else begin
            x = 16'($urandom);
            z = 16'($urandom);
            lvl = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
        end
        lookup(x, z, lvl, cur_frame);
    endtask

    task automatic test_random(int count);
        logic [7:0] limits [6];
        logic [7:0] floors [6];
        limits = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd2, 8'd3};
        floors = '{8'd0, 8'd0, 8'd16, 8'd5, 8'd2, 8'd0};
        limits[4] = 8'($urandom);
        floors[4] = 8'($urandom_range(0, 16));
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_BUILD_LIMIT, limits[ph]);
            write_reg(REG_MIN_LEVEL, floors[ph]);
            for (int i = 0; i < count / 6; i++) random_request();
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_left = 2500;
        for (int i = 0; i < 30; i++) random_request();
        drain();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.command = CMD_LOOKUP;
        req_ch.x_index = '0;
        req_ch.z_index = '0;
        req_ch.req_level = '0;
        req_ch.frame_number = '0;
        for (int i = 0; i < SLOTS; i++) begin
            dir_x[i] = '0;
            dir_z[i] = '0;
            dir_lvl[i] = '0;
            dir_valid[i] = 0;
            dir_stamp[i] = -1;
        end
        for (int i = 0; i < 24; i++) begin
            pool_x[i] = 16'($urandom_range(0, 255));
            pool_z[i] = 16'($urandom_range(0, 255));
        end
        build_count = 0;
        last_frame = '0;
        build_budget = BUILD_RESET;
        level_floor = '0;
        cur_frame = 31'd20;
        errors = 0;
        hold_left = 0;
        last_flush = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_budget_fallback();
        test_thrash();
        test_flush();
        test_random(1740);
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // result side: runs of ready, short stalls, rare long ones
    int run_left = 0;
    bit run_ready = 1'b1;
    initial rsp_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready = 1'b0;
        end else begin
            if (run_left == 0) begin
                run_ready = !run_ready;
                if (run_ready) run_left = $urandom_range(1, 40);
                else run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                              : $urandom_range(1, 3);
            end
            run_left = run_left - 1;
            rsp_ch.ready = run_ready;
        end
    end

    always @(posedge i_clk) begin
        t_tile_result got, want;
        cycles = cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.hit, rsp_ch.slot, rsp_ch.granted_level, rsp_ch.granted_x,
                   rsp_ch.granted_z, rsp_ch.built_new, rsp_ch.victim_valid, rsp_ch.thrash};
            if (tile_q.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = tile_q.pop_front();
                if (got !== want) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("mismatch: hit %b/%b slot %0d/%0d lvl %0d/%0d x %h/%h z %h/%h new %b/%b vict %b/%b thr %b/%b",
                                 want.hit, got.hit, want.slot, got.slot, want.level, got.level,
                                 want.x, got.x, want.z, got.z, want.built_new, got.built_new,
                                 want.victim_valid, got.victim_valid, want.thrash, got.thrash);
                end
            end
        end
    end

    initial cycles = 0;

endmodule
